[hdl/descending_score_leaderboard_unit_macros.svh]
// Assertion macros shared by the leaderboard RTL.
`ifndef DESCENDING_SCORE_LEADERBOARD_UNIT_MACROS_SVH
`define DESCENDING_SCORE_LEADERBOARD_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold in every cycle outside reset.
`define DSL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same-cycle implication.
`define DSL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define DSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DSL_ASSERT(label, clk, rst, prop, msg)
`define DSL_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/dsl_pkg.sv]
// Shared types and constants of the descending score leaderboard.
package dsl_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int SCORE_W      = 24;
  localparam int TAG_W        = 16;
  localparam int INDEX_W      = 3;
  localparam int PLACE_W      = 4;

  // Request kinds.
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_READ   = 1'b1
  } req_kind_t;

  // One stored record.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } record_t;

  // Control handed to each cell of the chain.
  typedef struct packed {
    logic insert;
    logic left_keep;
    logic occupied;
  } cell_ctrl_t;

  // One result item.
  typedef struct packed {
    logic [SCORE_W-1:0] score_out;
    logic [TAG_W-1:0]   tag_out;
    logic               entry_valid;
    logic [PLACE_W-1:0] place;
    logic [PLACE_W-1:0] entry_count;
  } result_t;

endpackage

[hdl/dsl_req_if.sv]
// Request channel of the leaderboard.
interface dsl_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [dsl_pkg::SCORE_W-1:0]  score_in;
  logic [dsl_pkg::TAG_W-1:0]    player_tag;
  logic [dsl_pkg::INDEX_W-1:0]  read_index;

  modport source (output valid, output req_type, output score_in, output player_tag,
                  output read_index, input ready);
  modport sink (input valid, input req_type, input score_in, input player_tag,
                input read_index, output ready);
endinterface

[hdl/dsl_res_if.sv]
// Result channel of the leaderboard.
interface dsl_res_if;
  logic                         valid;
  logic                         ready;
  logic [dsl_pkg::SCORE_W-1:0]  score_out;
  logic [dsl_pkg::TAG_W-1:0]    tag_out;
  logic                         entry_valid;
  logic [dsl_pkg::PLACE_W-1:0]  place;
  logic [dsl_pkg::PLACE_W-1:0]  entry_count;

  modport source (output valid, output score_out, output tag_out, output entry_valid,
                  output place, output entry_count, input ready);
  modport sink (input valid, input score_out, input tag_out, input entry_valid,
                input place, input entry_count, output ready);
endinterface

[hdl/dsl_cell.sv]
// One compare-and-shift cell of the sorted record chain.
module dsl_cell (
  input  logic                clk,
  input  dsl_pkg::cell_ctrl_t ctrl,
  input  dsl_pkg::record_t    new_rec,
  input  dsl_pkg::record_t    left_rec,
  output dsl_pkg::record_t    rec,
  output logic                keep
);

  // The cell keeps its record when it holds one that ranks at or above the new one.
  assign keep = ctrl.occupied && (rec.score >= new_rec.score);

  // On an insert a displaced cell takes the new record if its left neighbour stays,
  // otherwise it takes the neighbour's record as the list shifts down.
  always_ff @(posedge clk) begin
    if (ctrl.insert && !keep) begin
      if (ctrl.left_keep) begin
        rec <= new_rec;
      end else begin
        rec <= left_rec;
      end
    end
  end

endmodule

[hdl/dsl_obuf.sv]
// Two-entry output buffer that decouples the result channel from the request side.
module dsl_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  dsl_pkg::result_t   in_data,
  output logic               in_ready,
  output logic               out_valid,
  output dsl_pkg::result_t   out_data,
  input  logic               out_ready
);

  logic             skid_valid;
  dsl_pkg::result_t skid_data;
  logic             out_load;

  // New results are taken as long as the skid entry is free.
  assign in_ready = !skid_valid;
  assign out_load = !out_valid || out_ready;

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves from the skid entry first, so the order of results is kept.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

[hdl/descending_score_leaderboard_unit.sv]
// Each result is registered in the output buffer before it is offered.
// Throughput: one request per cycle when ready; every cell decides its move at once.
// A two-entry output buffer lets one further request in while a result is stalled.
// Reset (synchronous, active high) clears the record count; the cells keep their
// contents, which are never read before being written, so no clearing pass is needed.
`include "descending_score_leaderboard_unit_macros.svh"

module descending_score_leaderboard_unit #(
  parameter int CAPACITY = dsl_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  dsl_req_if.sink   req,
  dsl_res_if.source res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = dsl_pkg::PLACE_W;
  localparam int IW = dsl_pkg::INDEX_W;

  logic                 req_ready;
  logic                 req_fire;
  logic                 ins_fire;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CW-1:0]        ins_place;
  logic [CAPACITY-1:0]  keep;
  logic                 rd_valid;
  dsl_pkg::record_t     new_rec;
  dsl_pkg::record_t     rd_rec;
  dsl_pkg::record_t     rec [CAPACITY];
  dsl_pkg::cell_ctrl_t  ctrl [CAPACITY];
  dsl_pkg::result_t     res_new;
  dsl_pkg::result_t     res_data;

  assign req.ready = req_ready;
  assign req_fire  = req.valid && req_ready;
  assign ins_fire  = req_fire && (req.req_type == dsl_pkg::REQ_INSERT);
  assign new_rec   = '{score: req.score_in, tag: req.player_tag};

  // Chain of cells, each fed by its left neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign ctrl[i].left_keep = 1'b1;
      dsl_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl[i]),
        .new_rec  (new_rec),
        .left_rec (new_rec),
        .rec      (rec[i]),
        .keep     (keep[i])
      );
    end else begin : g_body
      assign ctrl[i].left_keep = keep[i-1];
      dsl_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl[i]),
        .new_rec  (new_rec),
        .left_rec (rec[i-1]),
        .rec      (rec[i]),
        .keep     (keep[i])
      );
    end
    assign ctrl[i].insert   = ins_fire;
    assign ctrl[i].occupied = CW'(i) < count;
  end

  // The insert place is the first cell that does not keep its record.
  always_comb begin
    ins_place = CW'(CAPACITY);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!keep[i]) begin
        ins_place = CW'(i);
      end
    end
  end

  // The count grows on an insert that is not dropped while the list has room.
  always_comb begin
    count_next = count;
    if (ins_fire && !keep[CAPACITY-1] && (count != CW'(CAPACITY))) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Read select over the cells.
  assign rd_valid = (int'(req.read_index) < int'(count)) && (int'(req.read_index) < CAPACITY);

  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((i < (1 << IW)) && (req.read_index == IW'(i))) begin
        rd_rec = rec[i];
      end
    end
  end

  // Result of the accepted request.
  always_comb begin
    res_new = '0;
    if (req.req_type == dsl_pkg::REQ_INSERT) begin
      res_new.place       = PW'(ins_place);
      res_new.entry_count = PW'(count_next);
    end else begin
      res_new.place       = PW'(CW'(CAPACITY));
      res_new.entry_count = PW'(count);
      if (rd_valid) begin
        res_new.entry_valid = 1'b1;
        res_new.score_out   = rd_rec.score;
        res_new.tag_out     = rd_rec.tag;
      end
    end
  end

  dsl_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_fire),
    .in_data   (res_new),
    .in_ready  (req_ready),
    .out_valid (res.valid),
    .out_data  (res_data),
    .out_ready (res.ready)
  );

  assign res.score_out   = res_data.score_out;
  assign res.tag_out     = res_data.tag_out;
  assign res.entry_valid = res_data.entry_valid;
  assign res.place       = res_data.place;
  assign res.entry_count = res_data.entry_count;

  // Checks on the record count and the insert decision.
  `DSL_ASSERT(a_count_bound, clk, rst, count <= CW'(CAPACITY), "record count above capacity")
  `DSL_ASSERT_NEXT(a_count_grows, clk, rst, ins_fire && (count != CW'(CAPACITY)), count == $past(count) + CW'(1), "insert into a list with room did not grow it")
  `DSL_ASSERT_NEXT(a_read_holds, clk, rst, req_fire && (req.req_type == dsl_pkg::REQ_READ), count == $past(count), "read changed the record count")
  `DSL_ASSERT_IMPL(a_no_drop, clk, rst, ins_fire && (count != CW'(CAPACITY)), ins_place != CW'(CAPACITY), "record dropped from a list with room")

endmodule
